// File: rtl/core/rom_cartridge_bank_pager_defines.svh
// Assertion macros for the cartridge bank pager checker.
`ifndef ROM_CARTRIDGE_BANK_PAGER_DEFINES_SVH
`define ROM_CARTRIDGE_BANK_PAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RCBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RCBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rcbp_pkg.sv
// Shared types and constants of the cartridge bank pager.
package rcbp_pkg;

  localparam int ROM_ADDR_BITS_DEF = 22;
  localparam int ROM_FULL_BITS     = 22;
  localparam int BANK_BITS         = 8;
  localparam int PREG_BITS         = 13;

  typedef struct packed {
    logic [15:0] access_address;
    logic        direct_access;
  } in_item_t;

  typedef struct packed {
    logic                     responds;
    logic                     idle_byte;
    logic [ROM_FULL_BITS-1:0] rom_address;
  } out_item_t;

  typedef enum logic [1:0] {
    RES_OFF  = 2'd0,
    RES_ROM  = 2'd1,
    RES_IDLE = 2'd2
  } res_kind_t;

  localparam logic [2:0] CART_NONE    = 3'd0;
  localparam logic [2:0] CART_PLAIN   = 3'd1;
  localparam logic [2:0] CART_BANK16  = 3'd2;
  localparam logic [2:0] CART_BANK8   = 3'd3;
  localparam logic [2:0] CART_BANKSET = 3'd4;

  localparam logic [15:0] UPPER_BASE  = 16'h3FC0;
  localparam logic [15:0] LOWER_LIMIT = 16'h2000;
  localparam logic [2:0]  SEL_LOWER   = 3'b011;
  localparam logic [2:0]  SEL_UPPER   = 3'b101;

  localparam logic [15:0] TRAP_PORT_A   = 16'h0008;
  localparam logic [15:0] TRAP_PORT_B   = 16'h1708;
  localparam logic [15:0] TRAP_PORT_END = 16'h0700;
  localparam logic [15:0] TRAP_TAPE_A   = 16'h0556;
  localparam logic [15:0] TRAP_TAPE_B   = 16'h04C2;
  localparam logic [15:0] TRAP_TAPE_END = 16'h0555;

  localparam int BIT_WRITE   = 3;
  localparam int BIT_PAGEOUT = 4;
  localparam int BIT_LOCK    = 5;
  localparam int BIT_TAPE    = 11;
  localparam int BIT_PORT    = 12;

endpackage

// File: rtl/core/rom_cartridge_bank_pager.sv
// Top level of the paged ROM cartridge bank pager.
// One CPU read is taken per cycle unless the input is stalled. A read sits in the input register
// from its transfer, is decoded in the following cycle and is then loaded into the result
// register, from which it is presented. A stalled result holds the result register and, when
// the input register holds a read, that register too, stalling the input in that same
// cycle; nothing else stalls the block. The single decode stage updates the paging state
// as each read passes, so back-to-back reads see each other's paging effects in order. The
// block returns only the ROM byte address, truncated to ROM_ADDR_BITS and zero above; the
// ROM itself lives outside. cartridge_type is written through cfg_wr_en/cfg_wr_data and
// should change only with no read in flight.
module rom_cartridge_bank_pager
  import rcbp_pkg::*;
#(
  parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic      item_valid;
  in_item_t  item;
  logic      ready;
  logic      fire;
  out_item_t result;

  assign fire = item_valid && ready;

  rcbp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .advance   (ready),
    .item_valid(item_valid),
    .item      (item)
  );

  rcbp_mapper u_mapper (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fire       (fire),
    .item       (item),
    .result     (result)
  );

  rcbp_out_reg #(
    .ROM_ADDR_BITS(ROM_ADDR_BITS)
  ) u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (item_valid),
    .result   (result),
    .ready    (ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/rcbp_in_reg.sv
// Input register stage of the cartridge bank pager.
module rcbp_in_reg
  import rcbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic in_xfer;

  assign in_stall = item_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_xfer) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= in_data;
    end
  end

endmodule

// File: rtl/core/rcbp_mapper.sv
// Paging state and per-access decode of the cartridge bank pager.
module rcbp_mapper
  import rcbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  logic [2:0]           cartridge_type;
  logic [PREG_BITS-1:0] paging_register;
  logic                 lower_window_selected;
  logic                 port_bank_paged_in;
  logic                 tape_bank_paged_in;

  logic [PREG_BITS-1:0] paging_register_next;
  logic                 lower_window_selected_next;
  logic                 port_bank_paged_in_next;
  logic                 tape_bank_paged_in_next;

  res_kind_t            res;
  logic [BANK_BITS-1:0] bank;
  logic [15:0]          addr;
  logic                 direct;
  logic                 in_cart;
  logic                 upper_area;
  logic                 autopaged;
  logic                 may;

  assign addr       = item.access_address;
  assign direct     = item.direct_access;
  assign in_cart    = (addr < 16'h4000);
  assign upper_area = (addr >= UPPER_BASE);
  assign autopaged  = port_bank_paged_in || tape_bank_paged_in;
  assign may        = (!direct && !paging_register[BIT_LOCK]) || autopaged;

  always_comb begin
    res                        = RES_OFF;
    bank                       = '0;
    paging_register_next       = paging_register;
    lower_window_selected_next = lower_window_selected;
    port_bank_paged_in_next    = port_bank_paged_in;
    tape_bank_paged_in_next    = tape_bank_paged_in;
    if (in_cart) begin
      case (cartridge_type)
        CART_PLAIN: begin
          res = RES_ROM;
        end
        CART_BANK16, CART_BANK8: begin
          if (!direct && upper_area && !paging_register[BIT_LOCK]) begin
            paging_register_next = {{(PREG_BITS-6){1'b0}}, addr[5:0]};
            res                  = RES_IDLE;
          end else if (paging_register[BIT_PAGEOUT]) begin
            res = RES_OFF;
          end else if (cartridge_type == CART_BANK8 && paging_register[BIT_WRITE]) begin
            res = RES_IDLE;
          end else begin
            res = RES_ROM;
            if (cartridge_type == CART_BANK8) begin
              bank = {5'b0, paging_register[2:0]};
            end else begin
              bank = {4'b0, paging_register[3:0]};
            end
          end
        end
        CART_BANKSET: begin
          if (may && !lower_window_selected && upper_area) begin
            if (addr[5:3] == SEL_LOWER) begin
              lower_window_selected_next = 1'b1;
            end else begin
              paging_register_next = {paging_register[PREG_BITS-1:6], addr[5:0]};
            end
            res = RES_IDLE;
          end else if (may && lower_window_selected && addr < LOWER_LIMIT) begin
            if (addr[5:3] == SEL_UPPER) begin
              lower_window_selected_next = 1'b0;
            end else begin
              paging_register_next = addr[PREG_BITS-1:0];
            end
            res = RES_IDLE;
          end else if (!paging_register[BIT_PAGEOUT] || autopaged) begin
            if (paging_register[BIT_WRITE]) begin
              res = RES_IDLE;
            end else begin
              res = RES_ROM;
              if (!autopaged ||
                  (!paging_register[BIT_PORT] && port_bank_paged_in) ||
                  (!paging_register[BIT_TAPE] && tape_bank_paged_in)) begin
                bank = {paging_register[10:6], paging_register[2:0]};
              end else begin
                bank = {paging_register[10:6], 2'b01, tape_bank_paged_in};
              end
            end
          end
          // trap checks see the register as just updated
          if (!direct) begin
            if (!port_bank_paged_in && !tape_bank_paged_in &&
                paging_register_next[BIT_PORT] &&
                (addr == TRAP_PORT_A || addr == TRAP_PORT_B)) begin
              port_bank_paged_in_next = 1'b1;
            end else if (port_bank_paged_in && paging_register_next[BIT_PORT] &&
                         addr == TRAP_PORT_END) begin
              port_bank_paged_in_next = 1'b0;
            end
            if (!port_bank_paged_in_next && !tape_bank_paged_in &&
                paging_register_next[BIT_TAPE] &&
                (addr == TRAP_TAPE_A || addr == TRAP_TAPE_B)) begin
              tape_bank_paged_in_next = 1'b1;
            end else if (tape_bank_paged_in && paging_register_next[BIT_TAPE] &&
                         (addr == TRAP_TAPE_A || addr == TRAP_TAPE_B ||
                          addr == TRAP_TAPE_END)) begin
              tape_bank_paged_in_next = 1'b0;
            end
          end
        end
        default: begin
          res = RES_OFF;
        end
      endcase
    end
  end

  always_comb begin
    result.responds    = (res != RES_OFF);
    result.idle_byte   = (res == RES_IDLE);
    result.rom_address = (res == RES_ROM) ? {bank, addr[13:0]} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cartridge_type        <= CART_NONE;
      paging_register       <= '0;
      lower_window_selected <= 1'b0;
      port_bank_paged_in    <= 1'b0;
      tape_bank_paged_in    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cartridge_type <= cfg_wr_data;
      end
      if (fire) begin
        paging_register       <= paging_register_next;
        lower_window_selected <= lower_window_selected_next;
        port_bank_paged_in    <= port_bank_paged_in_next;
        tape_bank_paged_in    <= tape_bank_paged_in_next;
      end
    end
  end

endmodule

// File: rtl/core/rcbp_out_reg.sv
// Result register of the cartridge bank pager.
module rcbp_out_reg
  import rcbp_pkg::*;
#(
  parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t result,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic                     responds;
  logic                     idle_byte;
  logic [ROM_ADDR_BITS-1:0] rom_address;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      responds    <= result.responds;
      idle_byte   <= result.idle_byte;
      rom_address <= result.rom_address[ROM_ADDR_BITS-1:0];
    end
  end

  assign out_data.responds    = responds;
  assign out_data.idle_byte   = idle_byte;
  assign out_data.rom_address = ROM_FULL_BITS'(rom_address);

endmodule

// File: rtl/core/rcbp_checker.sv
// Port-level checker of the cartridge bank pager, bound to the top level.
`include "rom_cartridge_bank_pager_defines.svh"

module rcbp_checker
  import rcbp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `RCBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled transfer changed")
  `RCBP_ASSERT_NOW(a_idle_responds, out_valid && out_data.idle_byte, out_data.responds, "idle byte without response")
  `RCBP_ASSERT_NOW(a_addr_zero, out_valid && (!out_data.responds || out_data.idle_byte), out_data.rom_address == '0, "address on non-ROM result")
  `RCBP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with output free")

endmodule

bind rom_cartridge_bank_pager rcbp_checker u_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the paged ROM cartridge bank pager: predicted reads vs block results.
`timescale 1ns / 1ps

module testbench;
  import rcbp_pkg::*;

  localparam int ROM_BITS = ROM_ADDR_BITS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] CART_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CART_UNUSED_MID = 3'd6;
  localparam logic [2:0] CART_UNUSED_HI  = 3'd7;

  class bank_pager_scoreboard;
    logic [2:0]  cart_type;
    logic [12:0] paging;
    bit          lower_sel;
    bit          port_in;
    bit          tape_in;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      cart_type = CART_NONE;
      paging    = '0;
      lower_sel = 1'b0;
      port_in   = 1'b0;
      tape_in   = 1'b0;
      errors    = 0;
    endfunction

    function void set_type(logic [2:0] t);
      cart_type = t;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the paging state for one accepted read and queue its result.
    function void note_read(in_item_t it);
      logic [15:0] a;
      bit          direct;
      res_kind_t   kind;
      logic [7:0]  bank;
      logic [2:0]  rb;
      logic [22:0] full;
      bit          autop;
      bit          may;
      out_item_t   e;
      a      = it.access_address;
      direct = it.direct_access;
      kind   = RES_OFF;
      bank   = '0;
      if (a < 16'h4000) begin
        case (cart_type)
          CART_PLAIN: begin
            kind = RES_ROM;
          end
          CART_BANK16, CART_BANK8: begin
            if (!direct && a >= UPPER_BASE && !paging[BIT_LOCK]) begin
              paging = {7'd0, a[5:0]};
              kind = RES_IDLE;
            end else if (paging[BIT_PAGEOUT]) begin
              kind = RES_OFF;
            end else if (cart_type == CART_BANK8 && paging[BIT_WRITE]) begin
              kind = RES_IDLE;
            end else begin
              kind = RES_ROM;
              bank = (cart_type == CART_BANK8) ? {5'd0, paging[2:0]} : {4'd0, paging[3:0]};
            end
          end
          CART_BANKSET: begin
            autop = port_in || tape_in;
            may = (!direct && !paging[BIT_LOCK]) || autop;
            if (may && !lower_sel && a >= UPPER_BASE) begin
              if (a[5:3] == SEL_LOWER) lower_sel = 1'b1;
              else paging[5:0] = a[5:0];
              kind = RES_IDLE;
            end else if (may && lower_sel && a < LOWER_LIMIT) begin
              if (a[5:3] == SEL_UPPER) lower_sel = 1'b0;
              else paging = a[12:0];
              kind = RES_IDLE;
            end else if (!paging[BIT_PAGEOUT] || autop) begin
              if (paging[BIT_WRITE]) begin
                kind = RES_IDLE;
              end else begin
                if (!autop || (!paging[BIT_PORT] && port_in) || (!paging[BIT_TAPE] && tape_in))
                  rb = paging[2:0];
                else
                  rb = tape_in ? 3'd3 : 3'd2;
                bank = {paging[10:6], rb};
                kind = RES_ROM;
              end
            end
            if (!direct) begin
              if (!port_in && !tape_in && paging[BIT_PORT] &&
                  (a == TRAP_PORT_A || a == TRAP_PORT_B))
                port_in = 1'b1;
              else if (port_in && paging[BIT_PORT] && a == TRAP_PORT_END)
                port_in = 1'b0;
              if (!port_in && !tape_in && paging[BIT_TAPE] &&
                  (a == TRAP_TAPE_A || a == TRAP_TAPE_B))
                tape_in = 1'b1;
              else if (tape_in && paging[BIT_TAPE] &&
                       (a == TRAP_TAPE_A || a == TRAP_TAPE_B || a == TRAP_TAPE_END))
                tape_in = 1'b0;
            end
          end
          default: kind = RES_OFF;
        endcase
      end
      full = {1'b0, bank, a[13:0]} & ((23'd1 << ROM_BITS) - 23'd1);
      e.responds    = (kind != RES_OFF);
      e.idle_byte   = (kind == RES_IDLE);
      e.rom_address = (kind == RES_ROM) ? full[21:0] : '0;
      expected_q.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.responds !== e.responds) begin
        $error("responds: expected %0d, got %0d", e.responds, got.responds);
        errors++;
      end
      if (got.idle_byte !== e.idle_byte) begin
        $error("idle_byte: expected %0d, got %0d", e.idle_byte, got.idle_byte);
        errors++;
      end
      if (got.rom_address !== e.rom_address) begin
        $error("rom_address: expected %h, got %h", e.rom_address, got.rom_address);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = CART_NONE;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  bank_pager_scoreboard sb = new();

  bit tx_steady = 1'b0;
  bit allow_hard_lock = 1'b0;
  int cycles = 0;
  int results_seen = 0;
  int rx_hold = 0;
  int rx_open = 0;

  rom_cartridge_bank_pager #(.ROM_ADDR_BITS(ROM_BITS)) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: check each transfer, stall in random bursts, long hold-offs now and then.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results_seen++;
      if (results_seen % 700 == 400) rx_hold = 300;
    end
    if (rx_hold == 0 && rx_open == 0) begin
      rx_hold = pick_gap();
      rx_open = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
      rx_open--;
    end
  end

  task automatic send_read(input logic [15:0] a, input logic d);
    in_item_t it;
    int gap;
    it.access_address = a;
    it.direct_access = d;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_read(it);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Type changes only with the block drained.
  task automatic write_cart_type(input logic [2:0] t);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_type(t);
  endtask

  task automatic run_phase(input logic [2:0] t, input int n);
    int r;
    logic [15:0] a;
    logic d;
    bit autop;
    bit may;
    write_cart_type(t);
    tx_steady = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      r = $urandom_range(0, 99);
      d = ($urandom_range(0, 4) == 0);
      a = {2'b00, 14'($urandom)};
      if (r < 8) begin
        a = 16'($urandom);
      end else if (t == CART_BANKSET) begin
        autop = sb.port_in || sb.tape_in;
        if (sb.paging[BIT_LOCK] && !autop && (sb.paging[BIT_PORT] || sb.paging[BIT_TAPE]) &&
            r < 50) begin
          // locked: trap back into an auto-paged bank to regain control
          a = sb.paging[BIT_PORT] ? TRAP_PORT_A : TRAP_TAPE_B;
          d = 1'b0;
        end else if (r < 30) begin
          if (sb.lower_sel) begin
            a = {3'b000, 13'($urandom)};
            if ($urandom_range(0, 3) == 0) a[5:3] = SEL_UPPER;
          end else begin
            a = UPPER_BASE | 16'(6'($urandom));
            if ($urandom_range(0, 5) == 0) a[5:3] = SEL_LOWER;
          end
        end else if (r < 55) begin
          case ($urandom_range(0, 5))
            0: a = TRAP_PORT_A;
            1: a = TRAP_PORT_B;
            2: a = TRAP_PORT_END;
            3: a = TRAP_TAPE_A;
            4: a = TRAP_TAPE_B;
            default: a = TRAP_TAPE_END;
          endcase
        end
        // never lock without an auto-paging way back out
        may = (!d && !sb.paging[BIT_LOCK]) || autop;
        if (!allow_hard_lock && may && !sb.lower_sel && a >= UPPER_BASE &&
            a[5:3] != SEL_LOWER && a[5] && !sb.paging[BIT_PORT] && !sb.paging[BIT_TAPE])
          a[5] = 1'b0;
        if (!allow_hard_lock && may && sb.lower_sel && a < LOWER_LIMIT &&
            a[5:3] != SEL_UPPER && a[5] && !a[12] && !a[11])
          a[12] = 1'b1;
      end else if (t == CART_BANK16 || t == CART_BANK8) begin
        if (r < 35) a = UPPER_BASE | 16'(6'($urandom));
        if (!allow_hard_lock && !d && a >= UPPER_BASE && !sb.paging[BIT_LOCK]) a[5] = 1'b0;
      end
      send_read(a, d);
    end
  endtask

  logic [2:0] phase_types [14] = '{CART_BANKSET, CART_BANK16, CART_BANKSET, CART_BANK8,
                                   CART_PLAIN, CART_BANKSET, CART_UNUSED_LO, CART_NONE,
                                   CART_BANKSET, CART_BANK16, CART_UNUSED_MID, CART_BANK8,
                                   CART_UNUSED_HI, CART_BANKSET};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_cart_type(CART_PLAIN);
    send_read(16'h0000, 1'b0);
    send_read(16'h3FFF, 1'b0);
    send_read(16'hFFFF, 1'b1);
    write_cart_type(CART_NONE);
    send_read(16'h1234, 1'b0);
    write_cart_type(CART_UNUSED_HI);
    send_read(16'h3FC5, 1'b0);

    write_cart_type(CART_BANK16);
    send_read(16'h3FCF, 1'b0);
    send_read(16'h2ABC, 1'b0);
    send_read(16'h3FC0, 1'b1);
    send_read(16'h3FD0, 1'b0);
    send_read(16'h0100, 1'b0);

    write_cart_type(CART_BANK8);
    send_read(16'h3FCF, 1'b0);
    send_read(16'h0001, 1'b0);

    // banked set: lower window, lock, port and tape auto-paging, then back to a clean state
    write_cart_type(CART_BANKSET);
    send_read(16'h3FD8, 1'b0);
    send_read(16'h1FFF, 1'b0);
    send_read(TRAP_PORT_A, 1'b0);
    send_read(16'h2000, 1'b0);
    send_read(16'h1828, 1'b0);
    send_read(16'h3FC0, 1'b0);
    send_read(16'h2345, 1'b0);
    send_read(TRAP_PORT_END, 1'b0);
    send_read(TRAP_TAPE_A, 1'b0);
    send_read(16'h1000, 1'b1);
    send_read(TRAP_TAPE_END, 1'b0);
    send_read(16'h3FD8, 1'b0);
    send_read(16'h0000, 1'b0);
    send_read(16'h1028, 1'b0);

    foreach (phase_types[k]) run_phase(phase_types[k], (phase_types[k] == CART_BANKSET) ? 220 : 90);

    // a lock in the simple schemes cannot be undone, so it goes last
    allow_hard_lock = 1'b1;
    write_cart_type(CART_BANK16);
    send_read(16'h3FE3, 1'b0);
    run_phase(CART_BANK16, 60);
    run_phase(CART_BANKSET, 60);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
